/* design/mbsd_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mbsd_pkg: shared types, constants and functions of the Morse bit decoder
// Holds the phase encoding, the letter table and the element/lookup helpers.
// ----------------------------------------------------------------------------
package mbsd_pkg;

    localparam int unsigned MaxElements = 4;     // dash bits kept per letter
    localparam int unsigned TableSize   = 26;

    localparam logic [3:0] GapReset = 4'd3;
    localparam logic [3:0] RunMax   = 4'd15;
    localparam logic [2:0] ElemMax  = 3'd7;

    // phase of the keyed word, one-hot
    typedef enum logic [2:0] {
        PH_LEAD = 3'b001,
        PH_TONE = 3'b010,
        PH_GAP  = 3'b100
    } t_phase;

    // one result transaction
    typedef struct packed {
        logic [4:0] letter;
        logic       has_letter;
        logic       word_end;
    } t_res;

    // element count and pattern of the letter being built
    typedef struct packed {
        logic [2:0] elem_cnt;
        logic [7:0] pattern;   // bit i: element i is a dash; bit 7: bad tone length
    } t_ltr;

    // high nibble element count, low nibble dash mask
    localparam logic [7:0] CodeTable [TableSize] = '{
        8'h22, 8'h41, 8'h45, 8'h31, 8'h10, 8'h44, 8'h33, 8'h40, 8'h20, 8'h4E,
        8'h35, 8'h42, 8'h23, 8'h21, 8'h37, 8'h46, 8'h4B, 8'h32, 8'h30, 8'h11,
        8'h34, 8'h48, 8'h36, 8'h49, 8'h4D, 8'h43
    };

    // closes a tone run of length run as one element of the letter
    function automatic t_ltr record_element(input t_ltr cur, input logic [3:0] run);
        t_ltr res;
        res = cur;
        if (run != 4'd1 && run != 4'd3) begin
            res.pattern[7] = 1'b1;
        end
        if ({29'd0, cur.elem_cnt} < MaxElements && run == 4'd3) begin
            res.pattern[cur.elem_cnt] = 1'b1;
        end
        if (cur.elem_cnt < ElemMax) begin
            res.elem_cnt = cur.elem_cnt + 3'd1;
        end
        return res;
    endfunction

    // table match, 0 for anything unrecognised
    function automatic logic [4:0] lookup_letter(input t_ltr cur);
        logic [7:0] key;
        logic [4:0] res;
        key = {1'b0, cur.elem_cnt, cur.pattern[3:0]};
        res = 5'd0;
        if (!(cur.pattern[7] || cur.elem_cnt == 3'd0 ||
              {29'd0, cur.elem_cnt} > MaxElements || cur.elem_cnt > 3'd4)) begin
            for (int i = 0; i < TableSize; i++) begin
                if (CodeTable[i] == key) begin
                    res = 5'(i + 1);
                end
            end
        end
        return res;
    endfunction

endpackage
`default_nettype wire

/* design/morse_bit_stream_decoder.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// morse_bit_stream_decoder: keyed time units in, letters A..Z out
// Run-length decodes dots, dashes and gaps of one word and looks each letter
// up in a fixed table; results leave through a four-entry output queue.
// ----------------------------------------------------------------------------
//
// channel  | handshake               | payload
// ---------+-------------------------+-------------------------------------
// input    | i_valid / o_stall       | i_bit_req, i_last
// output   | o_valid / i_stall       | o_letter, o_has_letter, o_word_end
// config   | i_cfg_we                | i_cfg_data (letter gap, reset 3)
//
// One unit is decoded in the cycle it is accepted; its results (at most two)
// are written to the output queue at that edge and show on o_valid next cycle.
// o_stall rises while the queue holds three or more transactions, so with the
// output side free one unit is taken every cycle.
// Synchronous active-low reset empties the queue and returns to leading silence.
// A stall on the output side fills the queue; results are never dropped.
// ----------------------------------------------------------------------------
module morse_bit_stream_decoder (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    // configuration
    input  wire logic       i_cfg_we,
    input  wire logic [3:0] i_cfg_data,
    // unit input
    input  wire logic       i_valid,
    output logic            o_stall,
    input  wire logic       i_bit_req,
    input  wire logic       i_last,
    // letter output
    output logic            o_valid,
    input  wire logic       i_stall,
    output logic [4:0]      o_letter,
    output logic            o_has_letter,
    output logic            o_word_end
);

    // ------------------------------------------------------------------
    // decoder state
    // ------------------------------------------------------------------
    logic [3:0]           r_gap,     n_gap;
    mbsd_pkg::t_phase     r_phase,   n_phase;
    logic [3:0]           r_run,     n_run;
    mbsd_pkg::t_ltr       r_ltr,     n_ltr;
    logic                 r_stopped, n_stopped;

    // output queue
    mbsd_pkg::t_res       r_q [4];
    logic [1:0]           r_head, n_head;
    logic [1:0]           r_tail, n_tail;
    logic [2:0]           r_count, n_count;

    logic                 acc;
    logic                 pop;
    logic                 emit_a, emit_b;
    mbsd_pkg::t_res       res_a, res_b;
    mbsd_pkg::t_res       slot0;
    logic [1:0]           push_n;

    assign o_stall = (r_count > 3'd2);
    assign o_valid = (r_count != 3'd0);
    assign acc     = i_valid && !o_stall;
    assign pop     = o_valid && !i_stall;

    assign o_letter     = r_q[r_head].letter;
    assign o_has_letter = r_q[r_head].has_letter;
    assign o_word_end   = r_q[r_head].word_end;

    // ------------------------------------------------------------------
    // per-unit decode
    // ------------------------------------------------------------------
    always_comb begin
        n_phase   = r_phase;
        n_run     = r_run;
        n_ltr     = r_ltr;
        n_stopped = r_stopped;
        emit_a    = 1'b0;
        emit_b    = 1'b0;
        res_a     = '0;
        res_b     = '0;

        if (r_stopped) begin
            // word abandoned after a bad gap: units are dropped until last
            if (i_last) begin
                n_stopped = 1'b0;
                n_phase   = mbsd_pkg::PH_LEAD;
                n_run     = 4'd0;
                n_ltr     = '0;
            end
        end else begin
            case (r_phase)
                mbsd_pkg::PH_TONE: begin
                    if (i_bit_req) begin
                        if (r_run < mbsd_pkg::RunMax) begin
                            n_run = r_run + 4'd1;
                        end
                    end else begin
                        n_ltr   = mbsd_pkg::record_element(r_ltr, r_run);
                        n_phase = mbsd_pkg::PH_GAP;
                        n_run   = 4'd1;
                    end
                end
                mbsd_pkg::PH_GAP: begin
                    if (!i_bit_req) begin
                        if (r_run < mbsd_pkg::RunMax) begin
                            n_run = r_run + 4'd1;
                        end
                    end else if (r_run == 4'd1) begin
                        n_phase = mbsd_pkg::PH_TONE;
                        n_run   = 4'd1;
                    end else if (r_run == r_gap) begin
                        // letter gap: letter done, word goes on
                        emit_a  = 1'b1;
                        res_a   = '{letter: mbsd_pkg::lookup_letter(r_ltr),
                                    has_letter: 1'b1, word_end: 1'b0};
                        n_ltr   = '0;
                        n_phase = mbsd_pkg::PH_TONE;
                        n_run   = 4'd1;
                    end else begin
                        // any other gap ends the word early
                        emit_a    = 1'b1;
                        res_a     = '{letter: mbsd_pkg::lookup_letter(r_ltr),
                                      has_letter: 1'b1, word_end: 1'b1};
                        n_ltr     = '0;
                        n_stopped = 1'b1;
                        n_phase   = mbsd_pkg::PH_LEAD;
                        n_run     = 4'd0;
                    end
                end
                mbsd_pkg::PH_LEAD: begin
                    if (i_bit_req) begin
                        n_phase = mbsd_pkg::PH_TONE;
                        n_run   = 4'd1;
                    end
                end
                default: begin
                    n_phase = mbsd_pkg::PH_LEAD;
                end
            endcase

            if (i_last) begin
                if (!n_stopped) begin
                    emit_b = 1'b1;
                    case (n_phase)
                        mbsd_pkg::PH_TONE: begin
                            res_b = '{letter: mbsd_pkg::lookup_letter(
                                          mbsd_pkg::record_element(n_ltr, n_run)),
                                      has_letter: 1'b1, word_end: 1'b1};
                        end
                        mbsd_pkg::PH_GAP: begin
                            res_b = '{letter: mbsd_pkg::lookup_letter(n_ltr),
                                      has_letter: 1'b1, word_end: 1'b1};
                        end
                        default: begin
                            // word without any tone
                            res_b = '{letter: 5'd0, has_letter: 1'b0, word_end: 1'b1};
                        end
                    endcase
                end
                n_stopped = 1'b0;
                n_phase   = mbsd_pkg::PH_LEAD;
                n_run     = 4'd0;
                n_ltr     = '0;
            end
        end
    end

    assign slot0  = emit_a ? res_a : res_b;
    assign push_n = acc ? ({1'b0, emit_a} + {1'b0, emit_b}) : 2'd0;

    assign n_gap   = i_cfg_we ? i_cfg_data : r_gap;
    assign n_tail  = r_tail + push_n;
    assign n_head  = r_head + {1'b0, pop};
    assign n_count = r_count + {1'b0, push_n} - {2'd0, pop};

    // ------------------------------------------------------------------
    // registers
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gap     <= mbsd_pkg::GapReset;
            r_phase   <= mbsd_pkg::PH_LEAD;
            r_run     <= 4'd0;
            r_ltr     <= '0;
            r_stopped <= 1'b0;
            r_head    <= 2'd0;
            r_tail    <= 2'd0;
            r_count   <= 3'd0;
        end else begin
            r_gap   <= n_gap;
            r_head  <= n_head;
            r_tail  <= n_tail;
            r_count <= n_count;
            if (acc) begin
                r_phase   <= n_phase;
                r_run     <= n_run;
                r_ltr     <= n_ltr;
                r_stopped <= n_stopped;
            end
        end
    end

    // queue storage, no reset needed
    always_ff @(posedge i_clk) begin
        if (push_n != 2'd0) begin
            r_q[r_tail] <= slot0;
        end
        if (push_n == 2'd2) begin
            r_q[r_tail + 2'd1] <= res_b;
        end
    end

    // ------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------
    a_queue_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= 3'd4)
        else $error("output queue overrun");

    a_last_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        acc && i_last |=> r_phase == mbsd_pkg::PH_LEAD && !r_stopped &&
                          r_ltr == '0 && r_run == 4'd0)
        else $error("word state not cleared after last unit");

    a_lead_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase == mbsd_pkg::PH_LEAD |-> r_ltr == '0)
        else $error("letter state held during leading silence");

    a_stopped_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_stopped |-> push_n == 2'd0)
        else $error("result produced from a stopped word");

    a_last_results: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        acc && i_last && !r_stopped |-> push_n != 2'd0)
        else $error("last unit of a live word gave no result");

endmodule
`default_nettype wire
